FILE: src/base64_line_packet_deframer_defines.svh
// Assertion macros shared by the deframer.
`ifndef BASE64_LINE_PACKET_DEFRAMER_DEFINES_SVH
`define BASE64_LINE_PACKET_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BLPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define BLPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/blpd_pkg.sv
package blpd_pkg;

  localparam int LINE_MAX   = 128;
  localparam int LINE_AW    = $clog2(LINE_MAX);
  localparam int LCW        = $clog2(LINE_MAX + 1);
  localparam int PACKET_BUF = 1024;
  localparam int PAW        = $clog2(PACKET_BUF);
  localparam int FILLW      = $clog2(PACKET_BUF + 1);
  localparam int CHUNK_MAX  = 96;
  localparam int CHW        = $clog2(CHUNK_MAX + 4);
  localparam int EXPW       = 17;
  localparam int IDXW       = 10;
  localparam int LENW       = 10;
  localparam int RAW        = ((PAW > IDXW) ? PAW : IDXW) + 1;

  localparam logic [7:0]  MARK_START_A = 8'h06;
  localparam logic [7:0]  MARK_START_B = 8'h09;
  localparam logic [7:0]  MARK_CONT_A  = 8'h04;
  localparam logic [7:0]  MARK_CONT_B  = 8'h14;
  localparam logic [7:0]  CH_LF        = 8'h0A;
  localparam logic [7:0]  CH_CR        = 8'h0D;
  localparam logic [7:0]  CH_PAD       = 8'h3D;
  localparam logic [15:0] POLY         = 16'h1021;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_RD_WAIT,
    ST_SCAN_CHK,
    ST_SCAN_WR,
    ST_LEN_CHK,
    ST_CRC,
    ST_POST
  } st_t;

  typedef struct packed {
    logic cap;
    logic line_wr;
    logic line_clr;
    logic err;
    logic good;
    logic asm_clr;
    logic pkt_start;
    logic rd_take;
    logic scan_start;
    logic scan_wr;
    logic scan_run;
    logic append;
    logic crc_start;
    logic crc_run;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic func1;
    logic eol;
    logic line_full;
    logic short_line;
    logic first;
    logic cont;
    logic assembling;
    logic len_bad;
    logic scan_done;
    logic scan_fail;
    logic over_buf;
    logic exp_reached;
    logic size_bad;
    logic crc_done;
    logic crc_ok;
    logic out_free;
  } sts_t;

  // Bit 6 flags a valid base64 character, bits 5:0 hold its value.
  function automatic logic [6:0] sextet(input logic [7:0] ch);
    logic [7:0] t;
    t = 8'd0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      t = ch - 8'h41;
      return {1'b1, t[5:0]};
    end
    if (ch >= 8'h61 && ch <= 8'h7A) begin
      t = ch - 8'h61 + 8'd26;
      return {1'b1, t[5:0]};
    end
    if (ch >= 8'h30 && ch <= 8'h39) begin
      t = ch - 8'h30 + 8'd52;
      return {1'b1, t[5:0]};
    end
    if (ch == 8'h2B) return {1'b1, 6'd62};
    if (ch == 8'h2F) return {1'b1, 6'd63};
    return 7'd0;
  endfunction

  // One byte of CRC-16/XMODEM, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    r = c ^ {d, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = r[15] ? ((r << 1) ^ POLY) : (r << 1);
    end
    return r;
  endfunction

endpackage

FILE: src/blpd_ctrl.sv
module blpd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  blpd_pkg::sts_t sts,
  output blpd_pkg::cmd_t cmd
);

  blpd_pkg::st_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= blpd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      blpd_pkg::ST_IDLE: begin
        if (in_valid) state_next = blpd_pkg::ST_DISPATCH;
      end
      blpd_pkg::ST_DISPATCH: begin
        if (sts.func1) begin
          state_next = blpd_pkg::ST_RD_WAIT;
        end else if (!sts.eol || sts.short_line || !(sts.first || sts.cont) ||
                     (!sts.first && !sts.assembling) || sts.len_bad) begin
          state_next = blpd_pkg::ST_POST;
        end else begin
          state_next = blpd_pkg::ST_SCAN_CHK;
        end
      end
      blpd_pkg::ST_RD_WAIT: state_next = blpd_pkg::ST_POST;
      blpd_pkg::ST_SCAN_CHK: begin
        if (sts.scan_done) begin
          state_next = (sts.scan_fail || sts.over_buf) ? blpd_pkg::ST_POST
                                                       : blpd_pkg::ST_SCAN_WR;
        end
      end
      blpd_pkg::ST_SCAN_WR: begin
        if (sts.scan_done) state_next = blpd_pkg::ST_LEN_CHK;
      end
      blpd_pkg::ST_LEN_CHK: begin
        state_next = (sts.exp_reached && !sts.size_bad) ? blpd_pkg::ST_CRC
                                                        : blpd_pkg::ST_POST;
      end
      blpd_pkg::ST_CRC: begin
        if (sts.crc_done) state_next = blpd_pkg::ST_POST;
      end
      blpd_pkg::ST_POST: begin
        if (sts.out_free) state_next = blpd_pkg::ST_IDLE;
      end
      default: state_next = blpd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      blpd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.cap  = in_valid;
      end
      blpd_pkg::ST_DISPATCH: begin
        if (!sts.func1) begin
          if (!sts.eol) begin
            if (sts.line_full) begin
              cmd.line_clr = 1'b1;
              cmd.err      = 1'b1;
              cmd.asm_clr  = 1'b1;
            end else begin
              cmd.line_wr = 1'b1;
            end
          end else if (!sts.short_line) begin
            if (!(sts.first || sts.cont) || (!sts.first && !sts.assembling)) begin
              cmd.err = 1'b1;
            end else begin
              cmd.pkt_start = sts.first;
              if (sts.len_bad) begin
                cmd.err     = 1'b1;
                cmd.asm_clr = 1'b1;
              end else begin
                cmd.scan_start = 1'b1;
              end
            end
          end
        end
      end
      blpd_pkg::ST_RD_WAIT: cmd.rd_take = 1'b1;
      blpd_pkg::ST_SCAN_CHK: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          if (sts.scan_fail || sts.over_buf) begin
            cmd.err     = 1'b1;
            cmd.asm_clr = 1'b1;
          end else begin
            cmd.scan_start = 1'b1;
            cmd.scan_wr    = 1'b1;
          end
        end
      end
      blpd_pkg::ST_SCAN_WR: begin
        cmd.scan_run = 1'b1;
        cmd.append   = sts.scan_done;
      end
      blpd_pkg::ST_LEN_CHK: begin
        if (sts.exp_reached) begin
          cmd.asm_clr   = 1'b1;
          cmd.err       = sts.size_bad;
          cmd.crc_start = !sts.size_bad;
        end
      end
      blpd_pkg::ST_CRC: begin
        cmd.crc_run = 1'b1;
        if (sts.crc_done) begin
          cmd.good = sts.crc_ok;
          cmd.err  = !sts.crc_ok;
        end
      end
      blpd_pkg::ST_POST: begin
        cmd.out_load = sts.out_free;
        cmd.line_clr = sts.out_free && sts.eol && !sts.func1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

FILE: src/blpd_dpath.sv
module blpd_dpath (
  input  logic           clk,
  input  logic           rst,
  input  blpd_pkg::cmd_t cmd,
  output blpd_pkg::sts_t sts,
  input  logic           in_func,
  input  logic [7:0]     in_byte,
  input  logic [blpd_pkg::IDXW-1:0] in_idx,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [87:0]    out_data
);

  // Captured item
  logic                      cap_func;
  logic [7:0]                cap_byte;
  logic [blpd_pkg::IDXW-1:0] cap_idx;

  // Line store
  logic [7:0]               line_mem [blpd_pkg::LINE_MAX];
  logic [7:0]               line_q;
  logic [blpd_pkg::LCW-1:0] line_count;
  logic [7:0]               m0, m1;

  // Packet store
  logic [7:0]                 pkt_mem [blpd_pkg::PACKET_BUF];
  logic [7:0]                 pkt_q;
  logic [blpd_pkg::PAW-1:0]   pkt_raddr;
  logic [blpd_pkg::FILLW-1:0] fill;
  logic [blpd_pkg::EXPW-1:0]  expected;
  logic                       assembling;
  logic [7:0]                 hdr0, hdr1;
  logic [blpd_pkg::RAW-1:0]   rd_full;
  logic                       rd_oob;

  // Base64 scan
  logic [blpd_pkg::LCW-1:0] iptr;
  logic                     scv;
  logic                     wr_mode;
  logic [1:0]               ppos;
  logic [5:0]               prev;
  logic [1:0]               qbytes;
  logic [blpd_pkg::CHW-1:0] ocnt;
  logic                     sfail;
  logic [6:0]               sx;
  logic                     is_pad;
  logic                     fail_c;
  logic                     emit;
  logic [7:0]               emit_byte;
  logic [5:0]               prev_next;
  logic [1:0]               qbytes_next;
  logic [blpd_pkg::CHW-1:0] ocnt_next;
  logic [blpd_pkg::CHW-1:0] osum;

  // CRC walk
  logic [blpd_pkg::FILLW-1:0] cptr;
  logic [blpd_pkg::FILLW-1:0] caddr;
  logic                       ccv;
  logic [15:0]                crc;
  logic [7:0]                 crc_hi, crc_lo;

  // Counters and result
  logic [31:0]               frame_errs, good_packets;
  logic                      res_ready, res_err;
  logic [blpd_pkg::LENW-1:0] res_len;
  logic [7:0]                res_rd;

  assign rd_full   = blpd_pkg::RAW'(cap_idx) + blpd_pkg::RAW'(2);
  assign rd_oob    = rd_full >= blpd_pkg::RAW'(blpd_pkg::PACKET_BUF);
  assign pkt_raddr = cmd.crc_run ? cptr[blpd_pkg::PAW-1:0] : rd_full[blpd_pkg::PAW-1:0];

  always_comb begin
    sx          = blpd_pkg::sextet(line_q);
    is_pad      = (line_q == blpd_pkg::CH_PAD);
    fail_c      = 1'b0;
    emit        = 1'b0;
    emit_byte   = 8'd0;
    prev_next   = prev;
    qbytes_next = qbytes;
    ocnt_next   = ocnt;
    osum        = ocnt + blpd_pkg::CHW'(qbytes);
    case (ppos)
      2'd0: begin
        fail_c    = !sx[6];
        prev_next = sx[5:0];
      end
      2'd1: begin
        fail_c      = !sx[6];
        emit        = 1'b1;
        emit_byte   = {prev, sx[5:4]};
        prev_next   = sx[5:0];
        qbytes_next = 2'd1;
      end
      2'd2: begin
        if (!is_pad) begin
          fail_c      = !sx[6];
          emit        = 1'b1;
          emit_byte   = {prev[3:0], sx[5:2]};
          prev_next   = sx[5:0];
          qbytes_next = 2'd2;
        end
      end
      default: begin
        if (!is_pad) begin
          fail_c      = !sx[6] || (qbytes != 2'd2);
          emit        = 1'b1;
          emit_byte   = {prev[1:0], sx[5:0]};
          qbytes_next = 2'd3;
        end
        osum      = ocnt + blpd_pkg::CHW'(qbytes_next);
        ocnt_next = osum;
        if (osum > blpd_pkg::CHW'(blpd_pkg::CHUNK_MAX)) fail_c = 1'b1;
      end
    endcase
  end

  // Memories
  always_ff @(posedge clk) begin
    if (cmd.line_wr) line_mem[line_count[blpd_pkg::LINE_AW-1:0]] <= cap_byte;
    line_q <= line_mem[iptr[blpd_pkg::LINE_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (scv && wr_mode && emit) pkt_mem[fill[blpd_pkg::PAW-1:0]] <= emit_byte;
    pkt_q <= pkt_mem[pkt_raddr];
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      cap_func <= in_func;
      cap_byte <= in_byte;
      cap_idx  <= in_idx;
    end
    if (cmd.line_wr && line_count == blpd_pkg::LCW'(0)) m0 <= cap_byte;
    if (cmd.line_wr && line_count == blpd_pkg::LCW'(1)) m1 <= cap_byte;
    if (scv && wr_mode && emit && fill == blpd_pkg::FILLW'(0)) hdr0 <= emit_byte;
    if (scv && wr_mode && emit && fill == blpd_pkg::FILLW'(1)) hdr1 <= emit_byte;
    if (cmd.scan_start) begin
      wr_mode <= cmd.scan_wr;
      ppos    <= 2'd0;
      prev    <= 6'd0;
      qbytes  <= 2'd0;
      ocnt    <= '0;
    end else if (cmd.scan_run && scv) begin
      ppos   <= ppos + 2'd1;
      prev   <= prev_next;
      qbytes <= qbytes_next;
      ocnt   <= ocnt_next;
    end
    if (cmd.crc_start) begin
      crc <= 16'd0;
    end else if (cmd.crc_run && ccv) begin
      if (blpd_pkg::EXPW'(caddr) < expected - blpd_pkg::EXPW'(2)) begin
        crc <= blpd_pkg::crc_byte(crc, pkt_q);
      end else if (blpd_pkg::EXPW'(caddr) == expected - blpd_pkg::EXPW'(2)) begin
        crc_hi <= pkt_q;
      end else begin
        crc_lo <= pkt_q;
      end
    end
    if (cmd.crc_run) caddr <= cptr;
    if (cmd.out_load) begin
      out_data <= {4'd0, good_packets, frame_errs, res_rd, res_err, res_len, res_ready};
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_count   <= '0;
      fill         <= '0;
      expected     <= '0;
      assembling   <= 1'b0;
      frame_errs   <= 32'd0;
      good_packets <= 32'd0;
      iptr         <= '0;
      scv          <= 1'b0;
      sfail        <= 1'b0;
      cptr         <= '0;
      ccv          <= 1'b0;
      res_ready    <= 1'b0;
      res_err      <= 1'b0;
      res_len      <= '0;
      res_rd       <= 8'd0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.cap) begin
        res_ready <= 1'b0;
        res_err   <= 1'b0;
        res_len   <= '0;
        res_rd    <= 8'd0;
      end
      if (cmd.line_clr) begin
        line_count <= '0;
      end else if (cmd.line_wr) begin
        line_count <= line_count + blpd_pkg::LCW'(1);
      end
      if (cmd.pkt_start) begin
        fill     <= '0;
        expected <= '0;
      end else if (scv && wr_mode && emit) begin
        fill <= fill + blpd_pkg::FILLW'(1);
      end else if (cmd.append && expected == '0 && fill >= blpd_pkg::FILLW'(2)) begin
        expected <= blpd_pkg::EXPW'({hdr0, hdr1}) + blpd_pkg::EXPW'(2);
      end
      if (cmd.asm_clr) begin
        assembling <= 1'b0;
      end else if (cmd.pkt_start) begin
        assembling <= 1'b1;
      end
      if (cmd.err) begin
        frame_errs <= frame_errs + 32'd1;
        res_err    <= 1'b1;
      end
      if (cmd.good) begin
        good_packets <= good_packets + 32'd1;
        res_ready    <= 1'b1;
        res_len      <= blpd_pkg::LENW'(expected - blpd_pkg::EXPW'(4));
      end
      if (cmd.rd_take) res_rd <= rd_oob ? 8'd0 : pkt_q;
      // Issue one line read a cycle; process the char in the cycle after its read.
      if (cmd.scan_start) begin
        iptr  <= blpd_pkg::LCW'(2);
        scv   <= 1'b0;
        sfail <= 1'b0;
      end else if (cmd.scan_run) begin
        if (iptr < line_count) begin
          iptr <= iptr + blpd_pkg::LCW'(1);
          scv  <= 1'b1;
        end else begin
          scv <= 1'b0;
        end
        if (scv && fail_c) sfail <= 1'b1;
      end
      if (cmd.crc_start) begin
        cptr <= blpd_pkg::FILLW'(2);
        ccv  <= 1'b0;
      end else if (cmd.crc_run) begin
        if (blpd_pkg::EXPW'(cptr) < expected) begin
          cptr <= cptr + blpd_pkg::FILLW'(1);
          ccv  <= 1'b1;
        end else begin
          ccv <= 1'b0;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.func1       = cap_func;
    sts.eol         = (cap_byte == blpd_pkg::CH_LF) || (cap_byte == blpd_pkg::CH_CR);
    sts.line_full   = line_count >= blpd_pkg::LCW'(blpd_pkg::LINE_MAX);
    sts.short_line  = line_count < blpd_pkg::LCW'(2);
    sts.first       = (m0 == blpd_pkg::MARK_START_A) && (m1 == blpd_pkg::MARK_START_B);
    sts.cont        = (m0 == blpd_pkg::MARK_CONT_A) && (m1 == blpd_pkg::MARK_CONT_B);
    sts.assembling  = assembling;
    sts.len_bad     = line_count[1:0] != 2'd2;
    sts.scan_done   = (iptr == line_count) && !scv;
    sts.scan_fail   = sfail;
    sts.over_buf    = (blpd_pkg::EXPW'(fill) + blpd_pkg::EXPW'(ocnt)) >
                      blpd_pkg::EXPW'(blpd_pkg::PACKET_BUF);
    sts.exp_reached = (expected != '0) && (blpd_pkg::EXPW'(fill) >= expected);
    sts.size_bad    = (blpd_pkg::EXPW'(fill) != expected) ||
                      (expected < blpd_pkg::EXPW'(4));
    sts.crc_done    = (blpd_pkg::EXPW'(cptr) == expected) && !ccv;
    sts.crc_ok      = crc == {crc_hi, crc_lo};
    sts.out_free    = !out_valid || out_ready;
  end

endmodule

FILE: src/base64_line_packet_deframer.sv
// Channel   Dir  Bits  Contents
// s_*       in   24+1  serial byte or payload read request
// m_*       out  88    one result item per accepted item
//
// A plain byte passes the accept, dispatch and post states; a payload read adds a wait
// state for the registered store read.
// A line end walks the stored line twice (check, then decode), then walks the packet
// store for the CRC when a packet completes.
// Synchronous active-high reset clears counters and control; the stores hold no reset.
// A stalled result holds in the output register while the next item may be accepted.
`include "base64_line_packet_deframer_defines.svh"

module base64_line_packet_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // data_byte[7:0], read_index[17:8], zero[23:18]
  input  logic [0:0]  s_tuser,   // func[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata    // packet_ready[0], packet_length[10:1],
                                 // frame_error[11], read_data[19:12],
                                 // bad_frame_total[51:20],
                                 // packet_total[83:52], zero[87:84]
);

  blpd_pkg::cmd_t cmd;
  blpd_pkg::sts_t sts;

  // Sequencer: accept, dispatch, run line/packet walks, post result.
  blpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Stores, base64 scan, CRC walk, counters and output register.
  blpd_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_func   (s_tuser[0]),
    .in_byte   (s_tdata[7:0]),
    .in_idx    (s_tdata[17:8]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

  // One item in flight: no accept right after an accept.
  `BLPD_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item accepted")
  // Never overwrite a result that still waits.
  `BLPD_ASSERT_NOW(a_out_free, cmd.out_load, sts.out_free, "result overwritten")
  // A line cannot both pass and fail.
  `BLPD_ASSERT_NOW(a_good_xor_err, cmd.good, !cmd.err, "good and bad at once")

endmodule

FILE: sim/base64_line_packet_deframer_tb.sv
module base64_line_packet_deframer_tb;

  localparam bit FN_BYTE = 1'b0;
  localparam bit FN_READ = 1'b1;
  localparam int CHUNK_BYTES = 93;  // largest whole-quad chunk a line can carry
  localparam int QUIET_TAIL = 120;  // final items sent with no idling
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    bit       func;
    bit [7:0] data;
    bit [9:0] idx;
  } serial_item_t;

  typedef struct {
    bit        ready;
    bit [9:0]  plen;
    bit        err;
    bit [7:0]  rd;
    bit [31:0] bad;
    bit [31:0] good;
  } deframe_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;

  base64_line_packet_deframer dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  serial_item_t pending[$];
  deframe_out_t expected_out[$];
  serial_item_t cur_item;
  int n_total = 1 << 30;
  int n_sent = 0;
  int errors = 0;
  int hiwater = 0;  // packet store bytes known written from index 0
  int src_gap = 0;
  int sink_hold = 0;
  bit pressed = 1'b0;
  bit next_valid;
  int idle_cnt = 0;

  // Shadow state of the deframer
  bit [7:0]  sh_line [blpd_pkg::LINE_MAX];
  int        sh_count;
  bit [7:0]  sh_pkt [blpd_pkg::PACKET_BUF];
  int        sh_fill;
  int        sh_expect;
  bit        sh_asm;
  bit [31:0] sh_bad;
  bit [31:0] sh_good;
  bit [7:0]  sh_chunk [blpd_pkg::CHUNK_MAX];

  function automatic int sextet_val(bit [7:0] ch);
    if (ch >= "A" && ch <= "Z") return ch - "A";
    if (ch >= "a" && ch <= "z") return ch - "a" + 26;
    if (ch >= "0" && ch <= "9") return ch - "0" + 52;
    if (ch == "+") return 62;
    if (ch == "/") return 63;
    return -1;
  endfunction

  function automatic bit [7:0] b64_char(int v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    return (v == 62) ? 8'h2B : 8'h2F;
  endfunction

  function automatic bit [15:0] xmodem_step(bit [15:0] c, bit [7:0] d);
    c = c ^ {d, 8'h00};
    for (int b = 0; b < 8; b++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    return c;
  endfunction

  // Decode the line body into sh_chunk; -1 on any base64 violation.
  function automatic int decode_line();
    int o;
    int a, b, c, d, nb;
    bit [23:0] v;
    o = 0;
    if ((sh_count - 2) % 4 != 0) return -1;
    for (int i = 2; i < sh_count; i += 4) begin
      a = sextet_val(sh_line[i]);
      b = sextet_val(sh_line[i+1]);
      if (a < 0 || b < 0) return -1;
      v = {a[5:0], b[5:0], 12'd0};
      nb = 1;
      if (sh_line[i+2] != blpd_pkg::CH_PAD) begin
        c = sextet_val(sh_line[i+2]);
        if (c < 0) return -1;
        v[11:6] = c[5:0];
        nb = 2;
      end
      if (sh_line[i+3] != blpd_pkg::CH_PAD) begin
        d = sextet_val(sh_line[i+3]);
        if (d < 0 || nb != 2) return -1;
        v[5:0] = d[5:0];
        nb = 3;
      end
      if (o + nb > blpd_pkg::CHUNK_MAX) return -1;
      sh_chunk[o++] = v[23:16];
      if (nb > 1) sh_chunk[o++] = v[15:8];
      if (nb > 2) sh_chunk[o++] = v[7:0];
    end
    return o;
  endfunction

  // Close the current line: 1 good packet, 2 bad frame, 0 nothing.
  function automatic int close_line(output int plen);
    bit first, cont;
    int got;
    bit [15:0] crc;
    plen = 0;
    if (sh_count < 2) return 0;
    first = sh_line[0] == blpd_pkg::MARK_START_A && sh_line[1] == blpd_pkg::MARK_START_B;
    cont = sh_line[0] == blpd_pkg::MARK_CONT_A && sh_line[1] == blpd_pkg::MARK_CONT_B;
    if (!first && !cont) return 2;
    if (first) begin
      sh_fill = 0;
      sh_expect = 0;
      sh_asm = 1'b1;
    end else if (!sh_asm) begin
      return 2;
    end
    got = decode_line();
    if (got < 0 || sh_fill + got > blpd_pkg::PACKET_BUF) begin
      sh_asm = 1'b0;
      return 2;
    end
    for (int i = 0; i < got; i++) sh_pkt[sh_fill + i] = sh_chunk[i];
    sh_fill += got;
    if (sh_expect == 0 && sh_fill >= 2) sh_expect = {sh_pkt[0], sh_pkt[1]} + 2;
    if (sh_expect == 0 || sh_fill < sh_expect) return 0;
    sh_asm = 1'b0;
    if (sh_fill != sh_expect || sh_expect < 4) return 2;
    plen = sh_expect - 4;
    crc = 16'd0;
    for (int i = 0; i < plen; i++) crc = xmodem_step(crc, sh_pkt[2 + i]);
    if (crc != {sh_pkt[2 + plen], sh_pkt[3 + plen]}) return 2;
    return 1;
  endfunction

  function automatic deframe_out_t deframe_predict(serial_item_t it);
    deframe_out_t r;
    int st, plen;
    r = '{default: 0};
    if (it.func == FN_READ) begin
      if (2 + it.idx < blpd_pkg::PACKET_BUF) r.rd = sh_pkt[2 + it.idx];
    end else if (it.data == blpd_pkg::CH_LF || it.data == blpd_pkg::CH_CR) begin
      st = close_line(plen);
      sh_count = 0;
      if (st == 1) begin
        sh_good++;
        r.ready = 1'b1;
        r.plen = plen[9:0];
      end else if (st == 2) begin
        sh_bad++;
        r.err = 1'b1;
      end
    end else if (sh_count < blpd_pkg::LINE_MAX) begin
      sh_line[sh_count++] = it.data;
    end else begin
      // overflow: drop the byte and the line
      sh_count = 0;
      sh_bad++;
      sh_asm = 1'b0;
      r.err = 1'b1;
    end
    r.bad = sh_bad;
    r.good = sh_good;
    return r;
  endfunction

  task automatic put_byte(bit [7:0] b);
    pending.push_back('{FN_BYTE, b, 10'd0});
  endtask

  task automatic put_read(bit [9:0] i);
    pending.push_back('{FN_READ, 8'($urandom_range(0, 255)), i});
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic put_eol();
    put_byte($urandom_range(0, 1) ? blpd_pkg::CH_LF : blpd_pkg::CH_CR);
  endtask

  // Issue a read of a byte known to be written, or past the store end.
  task automatic put_valid_read();
    if (hiwater < 3 || $urandom_range(0, 15) == 0) put_read(10'(1022 + $urandom_range(0, 1)));
    else put_read(10'($urandom_range(0, hiwater - 3)));
  endtask

  // Build one framed packet. fault: 0 clean, 1 bad CRC, 2 bad character,
  // 3 wrong length field.
  task automatic put_packet(int plen, int fault);
    bit [7:0] fr[$];
    bit [15:0] crc;
    bit [23:0] v;
    int lfield, pos, n, bad_line, line_no, q, nb;
    bit [7:0] enc[$];
    crc = 16'd0;
    lfield = (fault == 3) ? $urandom_range(0, 1) : plen + 2;
    fr.push_back(8'(lfield >> 8));
    fr.push_back(8'(lfield));
    for (int i = 0; i < plen; i++) begin
      fr.push_back(8'($urandom_range(0, 255)));
      crc = xmodem_step(crc, fr[$]);
    end
    if (fault == 1) crc ^= 16'(1 << $urandom_range(0, 15));
    fr.push_back(crc[15:8]);
    fr.push_back(crc[7:0]);
    put_eol();  // flush any partial line ahead of the packet
    pos = 0;
    line_no = 0;
    bad_line = $urandom_range(0, fr.size() / 3);
    while (pos < fr.size()) begin
      n = $urandom_range(1, (fr.size() - pos < CHUNK_BYTES) ? fr.size() - pos : CHUNK_BYTES);
      if (line_no == 0) begin
        put_byte(blpd_pkg::MARK_START_A);
        put_byte(blpd_pkg::MARK_START_B);
      end else begin
        put_byte(blpd_pkg::MARK_CONT_A);
        put_byte(blpd_pkg::MARK_CONT_B);
      end
      enc.delete();
      for (q = 0; q < n; q += 3) begin
        nb = (n - q < 3) ? n - q : 3;
        v = {fr[pos + q], (nb > 1) ? fr[pos + q + 1] : 8'd0, (nb > 2) ? fr[pos + q + 2] : 8'd0};
        enc.push_back(b64_char(v[23:18]));
        enc.push_back(b64_char(v[17:12]));
        enc.push_back((nb > 1) ? b64_char(v[11:6]) : blpd_pkg::CH_PAD);
        enc.push_back((nb > 2) ? b64_char(v[5:0]) : blpd_pkg::CH_PAD);
      end
      if (fault == 2 && (line_no == bad_line || pos + n >= fr.size()))
        enc[$urandom_range(0, enc.size() - 1)] = "*";
      foreach (enc[i]) put_byte(enc[i]);
      put_eol();
      pos += n;
      line_no++;
      if (fault == 2 && line_no > bad_line) fault = 4;
    end
    if (fault == 0 && fr.size() > hiwater) hiwater = fr.size();
  endtask

  task automatic put_noise(int n);
    for (int i = 0; i < n; i++) put_byte(8'($urandom_range(0, 255)));
    put_eol();
  endtask

  // Driver: hold each item until accepted, then idle in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      next_valid = s_tvalid;
      if (s_tvalid && s_tready) begin
        expected_out.push_back(deframe_predict(cur_item));
        n_sent++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (pending.size() > 0) begin
          cur_item = pending.pop_front();
          s_tdata <= {6'd0, cur_item.idx, cur_item.data};
          s_tuser <= cur_item.func;
          next_valid = 1'b1;
          if (n_sent + QUIET_TAIL < n_total && $urandom_range(0, 5) == 0)
            src_gap = $urandom_range(1, 10);
        end
      end
      s_tvalid <= next_valid;
    end
  end

  // Monitor: compare each result item with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_out.size() == 0) begin
          $display("%0t: unexpected result item %h", $time, m_tdata);
          errors++;
        end else begin
          deframe_out_t e;
          e = expected_out.pop_front();
          if (m_tdata[0] !== e.ready) begin
            $display("%0t: packet_ready exp %0d got %0d", $time, e.ready, m_tdata[0]);
            errors++;
          end
          if (m_tdata[10:1] !== e.plen) begin
            $display("%0t: packet_length exp %0d got %0d", $time, e.plen, m_tdata[10:1]);
            errors++;
          end
          if (m_tdata[11] !== e.err) begin
            $display("%0t: frame_error exp %0d got %0d", $time, e.err, m_tdata[11]);
            errors++;
          end
          if (m_tdata[19:12] !== e.rd) begin
            $display("%0t: read_data exp %h got %h", $time, e.rd, m_tdata[19:12]);
            errors++;
          end
          if (m_tdata[51:20] !== e.bad) begin
            $display("%0t: bad_frame_total exp %0d got %0d", $time, e.bad, m_tdata[51:20]);
            errors++;
          end
          if (m_tdata[83:52] !== e.good) begin
            $display("%0t: packet_total exp %0d got %0d", $time, e.good, m_tdata[83:52]);
            errors++;
          end
        end
      end
      // one long hold-off so the block backs up into its input
      if (!pressed && n_sent >= 200) begin
        pressed = 1'b1;
        sink_hold = 400;
      end
      if (sink_hold > 0) begin
        sink_hold--;
        m_tready <= 1'b0;
      end else if (n_sent + QUIET_TAIL < n_total && $urandom_range(0, 5) == 0) begin
        sink_hold = $urandom_range(0, 9);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int kind;
    sh_count = 0;
    sh_fill = 0;
    sh_expect = 0;
    sh_asm = 1'b0;
    sh_bad = '0;
    sh_good = '0;

    // Directed: out-of-range read, short lines, unknown marker, continuation while idle
    put_read(10'd1023);
    put_eol();
    put_text("A");
    put_eol();
    put_text("XYAAAA");
    put_eol();
    put_byte(blpd_pkg::MARK_CONT_A); put_byte(blpd_pkg::MARK_CONT_B);
    put_text("AAAA"); put_eol();
    // base64 faults: bad length, bad character, fourth after padded third
    put_byte(blpd_pkg::MARK_START_A); put_byte(blpd_pkg::MARK_START_B);
    put_text("AAA"); put_eol();
    put_byte(blpd_pkg::MARK_START_A); put_byte(blpd_pkg::MARK_START_B);
    put_text("A*AA"); put_eol();
    put_byte(blpd_pkg::MARK_START_A); put_byte(blpd_pkg::MARK_START_B);
    put_text("AA=A"); put_eol();
    // padding inside a line before its last quad
    put_byte(blpd_pkg::MARK_START_A); put_byte(blpd_pkg::MARK_START_B);
    put_text("AA==AAAA"); put_eol();
    // clean packets, extremes of payload size, faults, length field below 2
    put_packet(0, 0);
    put_packet(1, 0);
    put_packet(120, 0);
    put_packet(4, 1);
    put_packet(6, 3);
    put_valid_read();
    put_read(10'd0);
    put_read(10'd1022);
    // line overflow, then a packet that must still deframe
    put_noise(0);
    for (int i = 0; i < blpd_pkg::LINE_MAX + 1; i++) put_byte(8'(8'h41 + (i % 26)));
    put_packet(10, 0);
    put_read(10'(hiwater - 3));

    // Random: mostly well-formed packets, some broken ones, reads and noise
    while (pending.size() < 850) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) put_packet(($urandom_range(0, 9) == 0) ? $urandom_range(40, 250)
                                                           : $urandom_range(0, 24), 0);
      else if (kind < 70) put_packet($urandom_range(0, 24), $urandom_range(1, 3));
      else if (kind < 85) repeat ($urandom_range(1, 4)) put_valid_read();
      else if (kind < 98) put_noise($urandom_range(1, 20));
      else for (int i = 0; i < blpd_pkg::LINE_MAX + 3; i++)
        put_byte(8'($urandom_range(0, 255)));
    end
    n_total = pending.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    wait (n_sent == n_total && expected_out.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
